@@ rtl/assert_macros.svh @@
// assertion macros, empty bodies under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ATR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// condition must never be seen outside reset
`define ATR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define ATR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ATR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/atr_pkg.sv @@
package atr_pkg;

	// ring geometry
	localparam int unsigned BUF_WORDS_DEF = 2048;
	localparam int unsigned WORD_W        = 32;

	// register reset values
	localparam logic [11:0] PERIOD_RST     = 12'd256;
	localparam logic [10:0] OUTRUN_RST     = 11'd256;
	localparam logic [10:0] MAX_OUTRUN_RST = 11'd1024;
	localparam logic [10:0] QUANTUM_RST    = 11'd256;

	// word kinds on the request channel
	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_TICK  = 2'd1,
		FUNC_READ  = 2'd2
	} atr_func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DROP   = 2'd1,
		ST_REJECT = 2'd2
	} atr_status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PERIOD     = 2'd0,
		REG_OUTRUN     = 2'd1,
		REG_MAX_OUTRUN = 2'd2,
		REG_QUANTUM    = 2'd3
	} atr_reg_t;

	typedef struct packed {
		atr_func_t          func;
		logic               first_of_write;
		logic [WORD_W-1:0]  write_data;
		logic [10:0]        read_index;
	} atr_in_t;

	typedef struct packed {
		atr_status_t        status;
		logic               head_resynced;
		logic [10:0]        head_index;
		logic [10:0]        tail_index;
		logic [WORD_W-1:0]  read_data;
	} atr_out_t;

	typedef struct packed {
		atr_reg_t           index;
		logic [11:0]        wdata;
	} atr_cfg_t;

endpackage

@@ rtl/atr_stream_if.sv @@
interface atr_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/atr_ram.sv @@
module atr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read-first read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/audio_tx_ring_with_head_resync.sv @@
// Audio playback ring of 32-bit words with write-head resync.
// Channels: req carries one word per item (writer word, consumer period tick
// or consumer read-and-clear), rsp returns exactly one result word per item,
// cfg writes one of four registers (period, outrun, max outrun, quantum).
// Pointer update, resync, free-space check and the ring access all happen in
// the cycle the word is accepted; the ring's registered read (stage 1) and the
// output register follow, and a result shows on rsp from the output register.
// Throughput is one word per cycle while rsp moves and the clear is done, set
// by the ring's one write and one read port, each used at most once per word.
// After reset the block zeroes the ring one word per cycle, and req.ready stays
// low until every word (2048 by default) is clear; cfg is taken always.
// When rsp stalls, the output register holds its word and one more word can
// be accepted into the stage behind it; req.ready then drops until rsp moves.
// Config writes are meant for idle periods only.
`include "assert_macros.svh"

module audio_tx_ring_with_head_resync #(
	parameter int unsigned BUF_WORDS = atr_pkg::BUF_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	atr_stream_if.sink   req,
	atr_stream_if.source rsp,
	atr_stream_if.sink   cfg
);
	import atr_pkg::*;

	localparam int unsigned AW = $clog2(BUF_WORDS);
	localparam int unsigned CW = ((AW > 11) ? AW : 11) + 2;
	localparam logic [CW-1:0] RING_SIZE = CW'(BUF_WORDS);

	// config registers
	logic [11:0] period_q;
	logic [10:0] outrun_q;
	logic [10:0] max_outrun_q;
	logic [10:0] quantum_q;

	// ring pointers and burst state
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [11:0]   cnt_q;
	logic          rej_q;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// pipeline and output
	logic          valid_s1;
	logic          rd_s1;
	atr_out_t      meta_s1;
	logic          out_valid_q;
	atr_out_t      out_q;
	atr_out_t      out_nx;

	logic              fire;
	logic              adv_s1;
	logic              is_write;
	logic              is_tick;
	logic              is_read;
	logic              first;
	logic [CW-1:0]     h_ext;
	logic [CW-1:0]     t_ext;
	logic [CW-1:0]     o_ext;
	logic [CW-1:0]     m_ext;
	logic [CW-1:0]     resync_sum;
	logic [CW-1:0]     tail_sum;
	logic [CW-1:0]     ridx_ext;
	logic [CW-1:0]     head_nx_ext;
	logic [CW-1:0]     tail_nx_ext;
	logic              move;
	logic [AW-1:0]     head_eff;
	logic [AW-1:0]     space;
	logic              rej_eff;
	logic [11:0]       cnt_eff;
	logic              store;
	logic [AW-1:0]     head_nx;
	logic [AW-1:0]     tail_nx;
	logic [AW-1:0]     ridx;
	atr_status_t       status_nx;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	// handshakes
	assign cfg.ready = 1'b1;
	assign adv_s1    = valid_s1 & (~out_valid_q | rsp.ready);
	assign req.ready = ~clr_busy_q & (~valid_s1 | adv_s1);
	assign fire      = req.valid & req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// decode
	assign is_write = (req.data.func == FUNC_WRITE);
	assign is_tick  = (req.data.func == FUNC_TICK);
	assign is_read  = (req.data.func == FUNC_READ);
	assign first    = is_write & req.data.first_of_write;
	assign ridx_ext = CW'(req.data.read_index);
	assign ridx     = ridx_ext[AW-1:0];

	// head resync decision, wrap edge included
	assign h_ext      = CW'(head_q);
	assign t_ext      = CW'(tail_q);
	assign o_ext      = CW'(outrun_q);
	assign m_ext      = CW'(max_outrun_q);
	assign resync_sum = t_ext + o_ext;

	always_comb begin
		if (h_ext < resync_sum) begin
			if (t_ext + m_ext >= RING_SIZE) begin
				move = (h_ext + RING_SIZE > m_ext + t_ext);
			end else begin
				move = 1'b1;
			end
		end else begin
			move = (h_ext > t_ext + m_ext);
		end
	end

	// free space and burst admission
	assign head_eff = (first & move) ? resync_sum[AW-1:0] : head_q;
	assign space    = tail_q - head_eff - AW'(1);
	assign rej_eff  = first ? (CW'(space) < CW'(quantum_q)) : rej_q;
	assign cnt_eff  = first ? 12'd0 : cnt_q;
	assign store    = is_write & ~rej_eff & (cnt_eff < {1'b0, quantum_q});

	// next pointers
	assign tail_sum    = t_ext + CW'(period_q);
	assign head_nx     = !is_write ? head_q : (store ? head_eff + AW'(1) : head_eff);
	assign tail_nx     = is_tick ? tail_sum[AW-1:0] : tail_q;
	assign head_nx_ext = CW'(head_nx);
	assign tail_nx_ext = CW'(tail_nx);

	always_comb begin
		if (!is_write || store) begin
			status_nx = ST_OK;
		end else if (rej_eff) begin
			status_nx = ST_REJECT;
		end else begin
			status_nx = ST_DROP;
		end
	end

	// ring port: clearing pass, writer store or read-and-clear
	assign ram_we    = clr_busy_q | (fire & (store | is_read));
	assign ram_waddr = clr_busy_q ? clr_addr_q : (is_read ? ridx : head_eff);
	assign ram_wdata = (clr_busy_q | is_read) ? '0 : req.data.write_data;

	atr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BUF_WORDS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (fire & is_read),
		.raddr (ridx),
		.rdata (ram_rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RST;
			outrun_q     <= OUTRUN_RST;
			max_outrun_q <= MAX_OUTRUN_RST;
			quantum_q    <= QUANTUM_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_PERIOD:     period_q     <= cfg.data.wdata;
				REG_OUTRUN:     outrun_q     <= cfg.data.wdata[10:0];
				REG_MAX_OUTRUN: max_outrun_q <= cfg.data.wdata[10:0];
				REG_QUANTUM:    quantum_q    <= cfg.data.wdata[10:0];
				default: ;
			endcase
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// pointer and burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			rej_q  <= 1'b0;
		end else if (fire) begin
			head_q <= head_nx;
			tail_q <= tail_nx;
			if (is_write) begin
				cnt_q <= store ? cnt_eff + 12'd1 : cnt_eff;
				rej_q <= rej_eff;
			end
		end
	end

	// stage 1 valid, waits on the ring read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rd_s1                 <= is_read;
			meta_s1.status        <= status_nx;
			meta_s1.head_resynced <= first & move;
			meta_s1.head_index    <= head_nx_ext[10:0];
			meta_s1.tail_index    <= tail_nx_ext[10:0];
			meta_s1.read_data     <= '0;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// read word merged into the stage 1 payload
	always_comb begin
		out_nx           = meta_s1;
		out_nx.read_data = rd_s1 ? ram_rdata : '0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= out_nx;
		end
	end

	`ATR_ASSERT(a_clr_pipe_empty, clk, arst_n, clr_busy_q |-> !valid_s1 && !out_valid_q, "word in flight during ring clear")
	`ATR_ASSERT(a_s1_blocks_req, clk, arst_n, valid_s1 && !adv_s1 |-> !req.ready, "request taken while stage 1 is held")
	`ATR_ASSERT(a_head_only_on_write, clk, arst_n, !(fire && is_write) |=> $stable(head_q), "head moved on a non-writer word")
	`ATR_ASSERT_NEVER(a_read_clean, clk, arst_n, out_valid_q && out_q.read_data != '0 && (out_q.status != ST_OK || out_q.head_resynced), "read word carries writer status")
endmodule
